// ===== rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg: shared types and constants of the text console glyph renderer
// Opcodes, result kinds, register indexes, job descriptors and defaults.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   // default geometry of the font store and coordinates
   localparam int DEF_MAX_GLYPH_ROWS = 16;
   localparam int DEF_GLYPH_COUNT    = 256;
   localparam int DEF_COORD_BITS     = 12;

   // depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_DATA_W  = 12;
   localparam int GLYPH_H_W   = 6;
   localparam int COLOUR_W    = 32;
   localparam int ROW_W       = 8;

   localparam logic [CSR_DATA_W-1:0] RESET_SCREEN_W = 12'd1024;
   localparam logic [CSR_DATA_W-1:0] RESET_SCREEN_H = 12'd768;
   localparam logic [GLYPH_H_W-1:0]  RESET_GLYPH_H  = 6'd16;
   localparam logic [COLOUR_W-1:0]   RESET_COLOUR   = 32'h00FF_FFFF;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam int GLYPH_WIDTH   = 8;
   localparam int GLYPH_ADVANCE = GLYPH_WIDTH + 1;

   typedef enum logic [1:0] {
      OP_CHAR   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_CURSOR = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RSP_ROW   = 2'd0,
      RSP_CLEAR = 2'd1,
      RSP_ACK   = 2'd2
   } rsp_kind_type;

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_GLYPH_HEIGHT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      JOB_ACK   = 2'd0,
      JOB_CLEAR = 2'd1,
      JOB_LOAD  = 2'd2,
      JOB_DRAW  = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         pre_clear;   // draw job starts with a clear-to-black
   } job_ctrl_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SINGLE,
      BK_CLEAR,
      BK_ROWS
   } back_state_type;

endpackage

// ===== rtl/text_console_glyph_renderer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top: text console glyph renderer
// Cursor-tracking console that turns characters into glyph pixel rows.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (write char, load glyph row, set cursor,
//   clear). rsp_* returns the results of each item in order; rsp_last marks
//   the final result of an item. csr_* writes screen width, screen height
//   and glyph height; write only while no item is in flight.
// Path: an accepted item waits in the job queue, is popped into the job
//   register and leaves through the output register; a glyph row also
//   passes the glyph store's registered read port. The back end finishes
//   one item before it pops the next. A drawn character gives h rows
//   (h = glyph height), after a black clear when a wrap clear comes first.
//   Rows leave one per cycle from the single read port unless stalled.
//   A two-entry job queue lets the front take items while the back works.
// Reset: cursor to 0,0, text colour white, registers to 1024 x 768 with
//   16-row glyphs. The glyph store is not cleared; load rows before use.
// Stall: rsp_stall holds the output register; the back end freezes, the
//   queue fills and req_stall then rises.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top #(
   parameter int MAX_GLYPH_ROWS = tcgr_pkg::DEF_MAX_GLYPH_ROWS,
   parameter int GLYPH_COUNT    = tcgr_pkg::DEF_GLYPH_COUNT,
   parameter int COORD_BITS     = tcgr_pkg::DEF_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcgr_pkg::op_type       req_op,
   input  logic [7:0]             req_char_code,
   input  logic [4:0]             req_glyph_row,
   input  logic [7:0]             req_row_bits,
   input  logic [COORD_BITS-1:0]  req_cursor_x,
   input  logic [COORD_BITS-1:0]  req_cursor_y,
   input  logic [31:0]            req_colour_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcgr_pkg::rsp_kind_type rsp_kind,
   output logic [COORD_BITS-1:0]  rsp_pixel_x,
   output logic [COORD_BITS-1:0]  rsp_pixel_y,
   output logic [7:0]             rsp_pixel_mask,
   output logic [31:0]            rsp_paint_colour,
   output logic [COORD_BITS-1:0]  rsp_cursor_x_now,
   output logic [COORD_BITS-1:0]  rsp_cursor_y_now,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [1:0]             csr_addr,
   input  logic [11:0]            csr_wdata
);

   import tcgr_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int HW = $clog2(MAX_GLYPH_ROWS + 1);
   localparam int AW = $clog2(GLYPH_COUNT * MAX_GLYPH_ROWS);
   localparam int QW = $bits(job_ctrl_type) + 4 * C + AW + 8 + 32 + HW;

   logic          q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_din, q_dout;

   job_ctrl_type  f_ctrl, b_ctrl;
   logic [C-1:0]  f_px, f_py, f_cx, f_cy, b_px, b_py, b_cx, b_cy;
   logic [AW-1:0] f_addr, b_addr;
   logic [7:0]    f_wdata, b_wdata;
   logic [31:0]   f_colour, b_colour;
   logic [HW-1:0] f_rows, b_rows;

   tcgr_front #(
      .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
      .GLYPH_COUNT    (GLYPH_COUNT),
      .COORD_BITS     (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_char_code    (req_char_code),
      .req_glyph_row    (req_glyph_row),
      .req_row_bits     (req_row_bits),
      .req_cursor_x     (req_cursor_x),
      .req_cursor_y     (req_cursor_y),
      .req_colour_value (req_colour_value),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .q_push           (q_push),
      .job_ctrl         (f_ctrl),
      .job_px           (f_px),
      .job_py           (f_py),
      .job_addr         (f_addr),
      .job_wdata        (f_wdata),
      .job_colour       (f_colour),
      .job_cur_x        (f_cx),
      .job_cur_y        (f_cy),
      .job_rows         (f_rows)
   );

   assign q_din = {f_ctrl, f_px, f_py, f_addr, f_wdata, f_colour, f_cx, f_cy, f_rows};

   tcgr_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   assign {b_ctrl, b_px, b_py, b_addr, b_wdata, b_colour, b_cx, b_cy, b_rows} = q_dout;

   tcgr_back #(
      .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
      .GLYPH_COUNT    (GLYPH_COUNT),
      .COORD_BITS     (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .job_ctrl         (b_ctrl),
      .job_px           (b_px),
      .job_py           (b_py),
      .job_addr         (b_addr),
      .job_wdata        (b_wdata),
      .job_colour       (b_colour),
      .job_cur_x        (b_cx),
      .job_cur_y        (b_cy),
      .job_rows         (b_rows),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_mask   (rsp_pixel_mask),
      .rsp_paint_colour (rsp_paint_colour),
      .rsp_cursor_x_now (rsp_cursor_x_now),
      .rsp_cursor_y_now (rsp_cursor_y_now),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== rtl/tcgr_fifo.sv =====
// ----------------------------------------------------------------------------
// tcgr_fifo: job queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tcgr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/tcgr_front.sv =====
// ----------------------------------------------------------------------------
// tcgr_front: command front end
// Holds configuration, cursor and text colour; turns each item into a job.
// ----------------------------------------------------------------------------
module tcgr_front #(
   parameter int MAX_GLYPH_ROWS = 16,
   parameter int GLYPH_COUNT    = 256,
   parameter int COORD_BITS     = 12,
   localparam int HW = $clog2(MAX_GLYPH_ROWS + 1),
   localparam int AW = $clog2(GLYPH_COUNT * MAX_GLYPH_ROWS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcgr_pkg::op_type       req_op,
   input  logic [7:0]             req_char_code,
   input  logic [4:0]             req_glyph_row,
   input  logic [7:0]             req_row_bits,
   input  logic [COORD_BITS-1:0]  req_cursor_x,
   input  logic [COORD_BITS-1:0]  req_cursor_y,
   input  logic [31:0]            req_colour_value,
   input  logic                   csr_we,
   input  logic [1:0]             csr_addr,
   input  logic [11:0]            csr_wdata,
   input  logic                   q_full,
   output logic                   q_push,
   output tcgr_pkg::job_ctrl_type job_ctrl,
   output logic [COORD_BITS-1:0]  job_px,
   output logic [COORD_BITS-1:0]  job_py,
   output logic [AW-1:0]          job_addr,
   output logic [7:0]             job_wdata,
   output logic [31:0]            job_colour,
   output logic [COORD_BITS-1:0]  job_cur_x,
   output logic [COORD_BITS-1:0]  job_cur_y,
   output logic [HW-1:0]          job_rows
);

   import tcgr_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int EW = ((C > CSR_DATA_W) ? C : CSR_DATA_W) + 2;

   logic [CSR_DATA_W-1:0] screen_w_ff, screen_w_in;
   logic [CSR_DATA_W-1:0] screen_h_ff, screen_h_in;
   logic [GLYPH_H_W-1:0]  glyph_h_ff, glyph_h_in;
   logic [C-1:0]          cur_col_ff, cur_col_in;
   logic [C-1:0]          cur_line_ff, cur_line_in;
   logic [31:0]           text_colour_ff, text_colour_in;

   logic          accept;
   logic [HW-1:0] h_eff;
   logic [EW-1:0] line_adv, wrap_sum;
   logic          wrap_clear, need_wrap;
   logic [C-1:0]  new_line, draw_col, draw_line, next_col;
   logic [C:0]    col_sum;
   logic [9:0]    code_ext, glyph_idx;
   logic [AW-1:0] base_addr, load_addr;
   logic          load_ok;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign q_push    = accept;

   // configuration writes
   always_comb begin
      screen_w_in = screen_w_ff;
      screen_h_in = screen_h_ff;
      glyph_h_in  = glyph_h_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SCREEN_WIDTH:  screen_w_in = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_h_in = csr_wdata;
            CSR_GLYPH_HEIGHT:  glyph_h_in  = csr_wdata[GLYPH_H_W-1:0];
            default: ;
         endcase
      end
   end

   // line advance and wrap decisions, all from the current cursor
   always_comb begin
      if (glyph_h_ff == '0) begin
         h_eff = HW'(1);
      end else if (int'(glyph_h_ff) > MAX_GLYPH_ROWS) begin
         h_eff = HW'(MAX_GLYPH_ROWS);
      end else begin
         h_eff = HW'(glyph_h_ff);
      end
      line_adv   = EW'(cur_line_ff) + EW'(h_eff) + 1'b1;
      wrap_sum   = line_adv + EW'(h_eff) + 1'b1;
      wrap_clear = (wrap_sum >= EW'(screen_h_ff));
      new_line   = wrap_clear ? '0 : line_adv[C-1:0];
      need_wrap  = (EW'(cur_col_ff) + EW'(GLYPH_WIDTH)) > EW'(screen_w_ff);
      draw_col   = need_wrap ? '0 : cur_col_ff;
      draw_line  = need_wrap ? new_line : cur_line_ff;
      col_sum    = (C + 1)'(draw_col) + (C + 1)'(GLYPH_ADVANCE);
      next_col   = col_sum[C] ? '1 : col_sum[C-1:0];
   end

   // glyph store addressing; the code never reaches twice the glyph count
   always_comb begin
      code_ext  = 10'(req_char_code);
      glyph_idx = (code_ext >= 10'(GLYPH_COUNT)) ? code_ext - 10'(GLYPH_COUNT) : code_ext;
      base_addr = AW'(AW'(glyph_idx) * AW'(MAX_GLYPH_ROWS));
      load_addr = base_addr + AW'(req_glyph_row);
      load_ok   = ({1'b0, req_glyph_row} < 6'(MAX_GLYPH_ROWS));
   end

   always_comb begin
      job_ctrl.kind      = JOB_ACK;
      job_ctrl.pre_clear = 1'b0;
      job_px             = '0;
      job_py             = '0;
      job_addr           = base_addr;
      job_wdata          = req_row_bits;
      job_colour         = '0;
      job_rows           = h_eff;
      cur_col_in         = cur_col_ff;
      cur_line_in        = cur_line_ff;
      text_colour_in     = text_colour_ff;
      unique case (req_op)
         OP_CHAR: begin
            if (req_char_code == NEWLINE_CODE) begin
               cur_col_in  = '0;
               cur_line_in = new_line;
               if (wrap_clear) begin
                  job_ctrl.kind = JOB_CLEAR;
               end
            end else begin
               job_ctrl.kind      = JOB_DRAW;
               job_ctrl.pre_clear = need_wrap && wrap_clear;
               job_px             = draw_col;
               job_py             = draw_line;
               job_colour         = text_colour_ff;
               cur_col_in         = next_col;
               cur_line_in        = draw_line;
            end
         end
         OP_LOAD: begin
            job_addr = load_addr;
            if (load_ok) begin
               job_ctrl.kind = JOB_LOAD;
            end
         end
         OP_CURSOR: begin
            cur_col_in     = req_cursor_x;
            cur_line_in    = req_cursor_y;
            text_colour_in = req_colour_value;
         end
         OP_CLEAR: begin
            job_ctrl.kind = JOB_CLEAR;
            job_colour    = req_colour_value;
            cur_col_in    = '0;
            cur_line_in   = '0;
         end
      endcase
      job_cur_x = cur_col_in;
      job_cur_y = cur_line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff    <= RESET_SCREEN_W;
         screen_h_ff    <= RESET_SCREEN_H;
         glyph_h_ff     <= RESET_GLYPH_H;
         cur_col_ff     <= '0;
         cur_line_ff    <= '0;
         text_colour_ff <= RESET_COLOUR;
      end else begin
         screen_w_ff <= screen_w_in;
         screen_h_ff <= screen_h_in;
         glyph_h_ff  <= glyph_h_in;
         if (accept) begin
            cur_col_ff     <= cur_col_in;
            cur_line_ff    <= cur_line_in;
            text_colour_ff <= text_colour_in;
         end
      end
   end

endmodule

// ===== rtl/tcgr_back.sv =====
// ----------------------------------------------------------------------------
// tcgr_back: job execution and result output
// Owns the glyph store; emits clear, acknowledge and glyph row results.
// ----------------------------------------------------------------------------
module tcgr_back #(
   parameter int MAX_GLYPH_ROWS = 16,
   parameter int GLYPH_COUNT    = 256,
   parameter int COORD_BITS     = 12,
   localparam int HW = $clog2(MAX_GLYPH_ROWS + 1),
   localparam int AW = $clog2(GLYPH_COUNT * MAX_GLYPH_ROWS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  tcgr_pkg::job_ctrl_type job_ctrl,
   input  logic [COORD_BITS-1:0]  job_px,
   input  logic [COORD_BITS-1:0]  job_py,
   input  logic [AW-1:0]          job_addr,
   input  logic [7:0]             job_wdata,
   input  logic [31:0]            job_colour,
   input  logic [COORD_BITS-1:0]  job_cur_x,
   input  logic [COORD_BITS-1:0]  job_cur_y,
   input  logic [HW-1:0]          job_rows,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcgr_pkg::rsp_kind_type rsp_kind,
   output logic [COORD_BITS-1:0]  rsp_pixel_x,
   output logic [COORD_BITS-1:0]  rsp_pixel_y,
   output logic [7:0]             rsp_pixel_mask,
   output logic [31:0]            rsp_paint_colour,
   output logic [COORD_BITS-1:0]  rsp_cursor_x_now,
   output logic [COORD_BITS-1:0]  rsp_cursor_y_now,
   output logic                   rsp_last
);

   import tcgr_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;

   back_state_type state_ff, state_in;

   job_ctrl_type  jctrl_ff;
   logic [C-1:0]  jpx_ff, jpy_ff, jcx_ff, jcy_ff;
   logic [AW-1:0] jaddr_ff;
   logic [31:0]   jcolour_ff;
   logic [HW-1:0] jrows_ff;

   logic [7:0]    glyph_mem [DEPTH];
   logic [7:0]    mem_q_ff;
   logic [AW-1:0] rd_addr;

   logic [HW-1:0] f_row_ff, f_row_in;
   logic [HW-1:0] e_row_ff, e_row_in;
   logic          rd_vld_ff, rd_vld_in;

   logic          out_free, emit, wr_en, rd_en;
   rsp_kind_type  o_kind;
   logic [C-1:0]  o_px, o_py;
   logic [7:0]    o_mask;
   logic [31:0]   o_colour;
   logic          o_last;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_kind_type  rsp_kind_ff;
   logic [C-1:0]  rsp_px_ff, rsp_py_ff, rsp_cx_ff, rsp_cy_ff;
   logic [7:0]    rsp_mask_ff;
   logic [31:0]   rsp_colour_ff;
   logic          rsp_last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_addr  = jaddr_ff + AW'(f_row_ff);

   // sequencer outputs
   always_comb begin
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      emit     = 1'b0;
      o_kind   = RSP_ACK;
      o_px     = '0;
      o_py     = '0;
      o_mask   = '0;
      o_colour = '0;
      o_last   = 1'b1;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop = !q_empty;
            wr_en = !q_empty && (job_ctrl.kind == JOB_LOAD);
         end
         BK_SINGLE: begin
            emit = out_free;
            if (jctrl_ff.kind == JOB_CLEAR) begin
               o_kind   = RSP_CLEAR;
               o_colour = jcolour_ff;
            end
         end
         BK_CLEAR: begin
            // wrap clear ahead of the glyph rows, always black
            emit   = out_free;
            o_kind = RSP_CLEAR;
            o_last = 1'b0;
         end
         BK_ROWS: begin
            // one row fetched ahead so rows leave one per cycle while the output is free
            emit     = rd_vld_ff && out_free;
            rd_en    = (f_row_ff != jrows_ff) && (!rd_vld_ff || emit);
            o_kind   = RSP_ROW;
            o_px     = jpx_ff;
            o_py     = jpy_ff + C'(e_row_ff);
            o_mask   = mem_q_ff;
            o_colour = jcolour_ff;
            o_last   = ((e_row_ff + 1'b1) == jrows_ff);
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (job_ctrl.kind == JOB_DRAW) begin
                  state_in = job_ctrl.pre_clear ? BK_CLEAR : BK_ROWS;
               end else begin
                  state_in = BK_SINGLE;
               end
            end
         end
         BK_SINGLE: if (emit) state_in = BK_IDLE;
         BK_CLEAR:  if (emit) state_in = BK_ROWS;
         BK_ROWS:   if (emit && o_last) state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      f_row_in  = f_row_ff;
      e_row_in  = e_row_ff;
      rd_vld_in = rd_vld_ff;
      if (q_pop) begin
         f_row_in  = '0;
         e_row_in  = '0;
         rd_vld_in = 1'b0;
      end else begin
         if (rd_en) f_row_in = f_row_ff + 1'b1;
         if (emit && state_ff == BK_ROWS) e_row_in = e_row_ff + 1'b1;
         rd_vld_in = rd_en || (rd_vld_ff && !emit);
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         f_row_ff     <= '0;
         e_row_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         f_row_ff     <= f_row_in;
         e_row_ff     <= e_row_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         jctrl_ff   <= job_ctrl;
         jpx_ff     <= job_px;
         jpy_ff     <= job_py;
         jaddr_ff   <= job_addr;
         jcolour_ff <= job_colour;
         jcx_ff     <= job_cur_x;
         jcy_ff     <= job_cur_y;
         jrows_ff   <= job_rows;
      end
      if (emit) begin
         rsp_kind_ff   <= o_kind;
         rsp_px_ff     <= o_px;
         rsp_py_ff     <= o_py;
         rsp_mask_ff   <= o_mask;
         rsp_colour_ff <= o_colour;
         rsp_cx_ff     <= jcx_ff;
         rsp_cy_ff     <= jcy_ff;
         rsp_last_ff   <= o_last;
      end
   end

   // glyph store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         glyph_mem[job_addr] <= job_wdata;
      end
      if (rd_en) begin
         mem_q_ff <= glyph_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_pixel_x      = rsp_px_ff;
   assign rsp_pixel_y      = rsp_py_ff;
   assign rsp_pixel_mask   = rsp_mask_ff;
   assign rsp_paint_colour = rsp_colour_ff;
   assign rsp_cursor_x_now = rsp_cx_ff;
   assign rsp_cursor_y_now = rsp_cy_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== rtl/tcgr_checker.sv =====
// ----------------------------------------------------------------------------
// tcgr_checker: port-level checks of the glyph renderer
// Result channel rules seen at the top level ports, bound to the top.
// ----------------------------------------------------------------------------
module tcgr_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input tcgr_pkg::rsp_kind_type rsp_kind,
   input logic [COORD_BITS-1:0]  rsp_pixel_x,
   input logic [COORD_BITS-1:0]  rsp_pixel_y,
   input logic [7:0]             rsp_pixel_mask,
   input logic [31:0]            rsp_paint_colour,
   input logic [COORD_BITS-1:0]  rsp_cursor_x_now,
   input logic [COORD_BITS-1:0]  rsp_cursor_y_now,
   input logic                   rsp_last
);

   import tcgr_pkg::*;

   // stalled result holds its kind, y, mask, cursor and last fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_pixel_y)
         && $stable(rsp_pixel_mask) && $stable(rsp_cursor_x_now)
         && $stable(rsp_cursor_y_now) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_nonrow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != RSP_ROW |->
         rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_mask == '0)
      else $error("pixel fields set on a non-row result");

   a_ack_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == RSP_ACK |-> rsp_last && rsp_paint_colour == '0)
      else $error("acknowledge not a lone black result");

   // a clear followed by more results of the same item is a wrap clear
   a_wrap_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == RSP_CLEAR && !rsp_last |-> rsp_paint_colour == '0)
      else $error("wrap clear not black");

endmodule

bind text_console_glyph_renderer_top tcgr_checker #(
   .COORD_BITS (COORD_BITS)
) u_tcgr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_pixel_x      (rsp_pixel_x),
   .rsp_pixel_y      (rsp_pixel_y),
   .rsp_pixel_mask   (rsp_pixel_mask),
   .rsp_paint_colour (rsp_paint_colour),
   .rsp_cursor_x_now (rsp_cursor_x_now),
   .rsp_cursor_y_now (rsp_cursor_y_now),
   .rsp_last         (rsp_last)
);

// ===== tb/text_console_glyph_renderer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top_tb: self-checking bench for the console
// A stimulus table first, then random command mixes under four screen and
// font settings. Each item is scored against a cursor and glyph-store model,
// with random idling on both channels and a long output hold.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top_tb;
   import tcgr_pkg::*;

   localparam int COORD_MAX      = (1 << DEF_COORD_BITS) - 1;
   localparam int QUIET_LIMIT    = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int ITEMS_PER_SET  = 35;

   typedef struct {
      op_type      op;
      logic [7:0]  char_code;
      logic [4:0]  glyph_row;
      logic [7:0]  row_bits;
      logic [11:0] cursor_x;
      logic [11:0] cursor_y;
      logic [31:0] colour;
   } console_cmd_type;

   typedef struct {
      rsp_kind_type kind;
      logic [11:0]  px;
      logic [11:0]  py;
      logic [7:0]   mask;
      logic [31:0]  colour;
      logic [11:0]  cx;
      logic [11:0]  cy;
      logic         last;
   } paint_type;

   typedef struct {
      bit              reg_write;
      csr_index_type   reg_idx;
      logic [11:0]     reg_val;
      console_cmd_type cmd;
      bit              known;
      paint_type       want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   op_type      req_op = OP_CHAR;
   logic [7:0]  req_char_code = '0;
   logic [4:0]  req_glyph_row = '0;
   logic [7:0]  req_row_bits = '0;
   logic [11:0] req_cursor_x = '0;
   logic [11:0] req_cursor_y = '0;
   logic [31:0] req_colour_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_kind_type rsp_kind;
   logic [11:0] rsp_pixel_x;
   logic [11:0] rsp_pixel_y;
   logic [7:0]  rsp_pixel_mask;
   logic [31:0] rsp_paint_colour;
   logic [11:0] rsp_cursor_x_now;
   logic [11:0] rsp_cursor_y_now;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [11:0] csr_wdata = '0;

   // console model state
   int          scr_w = 1024;
   int          scr_h = 768;
   int          font_h = 16;
   int          col_now = 0;
   int          line_now = 0;
   logic [31:0] ink = RESET_COLOUR;
   logic [7:0]  font_rows [DEF_GLYPH_COUNT][DEF_MAX_GLYPH_ROWS];
   bit          font_loaded [DEF_GLYPH_COUNT][DEF_MAX_GLYPH_ROWS];

   // glyphs drawn by the random part, shared by all settings
   logic [7:0]  faces [4];

   paint_type      item_paints[$];
   paint_type      pending_paints[$];
   script_row_type script[$];

   int tx_idle_pct = 6;
   int rx_idle_pct = 46;
   int holds_asked = 0;
   int holds_given = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int items_sent = 0;
   int paints_checked = 0;
   int reg_writes = 0;
   int mismatches = 0;

   text_console_glyph_renderer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_char_code    (req_char_code),
      .req_glyph_row    (req_glyph_row),
      .req_row_bits     (req_row_bits),
      .req_cursor_x     (req_cursor_x),
      .req_cursor_y     (req_cursor_y),
      .req_colour_value (req_colour_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_mask   (rsp_pixel_mask),
      .rsp_paint_colour (rsp_paint_colour),
      .rsp_cursor_x_now (rsp_cursor_x_now),
      .rsp_cursor_y_now (rsp_cursor_y_now),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic int rows_per_glyph();
      if (font_h == 0) return 1;
      if (font_h > DEF_MAX_GLYPH_ROWS) return DEF_MAX_GLYPH_ROWS;
      return font_h;
   endfunction

   function automatic paint_type paint_of(rsp_kind_type k, int px, int py,
                                          logic [7:0] m, logic [31:0] c);
      paint_type p;
      p.kind   = k;
      p.px     = px[11:0];
      p.py     = py[11:0];
      p.mask   = m;
      p.colour = c;
      p.cx     = '0;
      p.cy     = '0;
      p.last   = 1'b0;
      return p;
   endfunction

   function automatic void line_feed(int h);
      int ny;
      ny = line_now + h + 1;
      col_now = 0;
      if (ny + h + 1 >= scr_h) begin
         line_now = 0;
         item_paints.push_back(paint_of(RSP_CLEAR, 0, 0, 8'h00, 32'h0));
      end else begin
         line_now = ny & COORD_MAX;
      end
   endfunction

   // applies one accepted item to the model and queues the paints it causes
   function automatic void render_item(console_cmd_type c);
      int h;
      int nx;
      int dy;
      h = rows_per_glyph();
      item_paints.delete();
      case (c.op)
         OP_CHAR: begin
            if (c.char_code == NEWLINE_CODE) begin
               line_feed(h);
            end else begin
               if (col_now + GLYPH_WIDTH > scr_w) line_feed(h);
               for (dy = 0; dy < h; dy++)
                  item_paints.push_back(paint_of(RSP_ROW, col_now, line_now + dy,
                                                 font_rows[c.char_code][dy], ink));
               nx = col_now + GLYPH_ADVANCE;
               col_now = (nx > COORD_MAX) ? COORD_MAX : nx;
            end
            if (item_paints.size() == 0)
               item_paints.push_back(paint_of(RSP_ACK, 0, 0, 8'h00, 32'h0));
         end
         OP_LOAD: begin
            // rows past the store are dropped
            if (c.glyph_row < DEF_MAX_GLYPH_ROWS) begin
               font_rows[c.char_code][c.glyph_row[3:0]]   = c.row_bits;
               font_loaded[c.char_code][c.glyph_row[3:0]] = 1'b1;
            end
            item_paints.push_back(paint_of(RSP_ACK, 0, 0, 8'h00, 32'h0));
         end
         OP_CURSOR: begin
            col_now  = c.cursor_x;
            line_now = c.cursor_y;
            ink      = c.colour;
            item_paints.push_back(paint_of(RSP_ACK, 0, 0, 8'h00, 32'h0));
         end
         default: begin
            col_now  = 0;
            line_now = 0;
            item_paints.push_back(paint_of(RSP_CLEAR, 0, 0, 8'h00, c.colour));
         end
      endcase
      foreach (item_paints[k]) begin
         item_paints[k].cx   = col_now[11:0];
         item_paints[k].cy   = line_now[11:0];
         item_paints[k].last = (k == item_paints.size() - 1);
         pending_paints.push_back(item_paints[k]);
      end
   endfunction

   // ------------------------------------------------------------ stimulus
   function automatic console_cmd_type cmd_of(op_type op, int ch, int grow, int bits,
                                              int x, int y, logic [31:0] colour);
      console_cmd_type c;
      c.op        = op;
      c.char_code = ch[7:0];
      c.glyph_row = grow[4:0];
      c.row_bits  = bits[7:0];
      c.cursor_x  = x[11:0];
      c.cursor_y  = y[11:0];
      c.colour    = colour;
      return c;
   endfunction

   function automatic console_cmd_type random_cmd(op_type op);
      console_cmd_type c;
      c.op        = op;
      c.char_code = 8'($urandom);
      c.glyph_row = 5'($urandom);
      c.row_bits  = 8'($urandom);
      c.cursor_x  = 12'($urandom);
      c.cursor_y  = 12'($urandom);
      c.colour    = $urandom;
      return c;
   endfunction

   function automatic void plan(console_cmd_type c);
      script_row_type s;
      s.reg_write = 1'b0;
      s.reg_idx   = CSR_SCREEN_WIDTH;
      s.reg_val   = '0;
      s.cmd       = c;
      s.known     = 1'b0;
      s.want      = paint_of(RSP_ACK, 0, 0, 8'h00, 32'h0);
      script.push_back(s);
   endfunction

   // single-result item whose outcome is obvious by inspection
   function automatic void plan_known(console_cmd_type c, rsp_kind_type k,
                                      logic [31:0] colour, int cx, int cy);
      plan(c);
      script[$].known   = 1'b1;
      script[$].want    = paint_of(k, 0, 0, 8'h00, colour);
      script[$].want.cx = cx[11:0];
      script[$].want.cy = cy[11:0];
      script[$].want.last = 1'b1;
   endfunction

   function automatic void plan_reg(csr_index_type idx, int val);
      plan(cmd_of(OP_CHAR, 0, 0, 0, 0, 0, 32'h0));
      script[$].reg_write = 1'b1;
      script[$].reg_idx   = idx;
      script[$].reg_val   = val[11:0];
   endfunction

   task automatic send_cmd(console_cmd_type c);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= c.op;
      req_char_code    <= c.char_code;
      req_glyph_row    <= c.glyph_row;
      req_row_bits     <= c.row_bits;
      req_cursor_x     <= c.cursor_x;
      req_cursor_y     <= c.cursor_y;
      req_colour_value <= c.colour;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      render_item(c);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_paints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [11:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SCREEN_WIDTH:  scr_w  = val;
         CSR_SCREEN_HEIGHT: scr_h  = val;
         default:           font_h = val & 12'h3F;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // loads any glyph row a draw would read that was never written
   task automatic preload_glyph(logic [7:0] code);
      console_cmd_type c;
      int h;
      int r;
      h = rows_per_glyph();
      for (r = 0; r < h; r++) begin
         if (!font_loaded[code][r]) begin
            c = random_cmd(OP_LOAD);
            c.char_code = code;
            c.glyph_row = r[4:0];
            send_cmd(c);
         end
      end
   endtask

   task automatic run_setting(int w, int hgt, int gh, int tx_pct, int rx_pct,
                              bit squeeze);
      console_cmd_type c;
      int              pick;
      int              n;
      int              lo;
      wait_drained();
      write_reg(CSR_SCREEN_WIDTH, w[11:0]);
      write_reg(CSR_SCREEN_HEIGHT, hgt[11:0]);
      write_reg(CSR_GLYPH_HEIGHT, gh[11:0]);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (n = 0; n < ITEMS_PER_SET; n++) begin
         if (squeeze && n == ITEMS_PER_SET / 3) holds_asked++;
         if (squeeze && n == 2 * ITEMS_PER_SET / 3) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            c = random_cmd(OP_CHAR);
            c.char_code = faces[$urandom_range(0, 3)];
            preload_glyph(c.char_code);
         end else if (pick < 60) begin
            c = random_cmd(OP_CHAR);
            c.char_code = NEWLINE_CODE;
         end else if (pick < 72) begin
            c = random_cmd(OP_LOAD);
         end else if (pick < 88) begin
            c = random_cmd(OP_CURSOR);
            case ($urandom_range(0, 3))
               0: ;  // anywhere in the coordinate space
               1: begin
                  lo = (scr_w > 24) ? scr_w - 24 : 0;
                  c.cursor_x = 12'($urandom_range(lo, scr_w));
                  c.cursor_y = 12'($urandom_range(0, scr_h));
               end
               default: begin
                  c.cursor_x = 12'($urandom_range(0, scr_w));
                  c.cursor_y = 12'($urandom_range(0, scr_h));
               end
            endcase
         end else begin
            c = random_cmd(OP_CLEAR);
         end
         send_cmd(c);
      end
   endtask

   // ------------------------------------------------------------ receiver
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_given < holds_asked) begin
         holds_given++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin : check_paints
      paint_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         paints_checked++;
         if (pending_paints.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected result kind=%0d x=%0d y=%0d", $realtime,
                        rsp_kind, rsp_pixel_x, rsp_pixel_y);
         end else begin
            want = pending_paints.pop_front();
            if (rsp_kind !== want.kind || rsp_pixel_x !== want.px ||
                rsp_pixel_y !== want.py || rsp_pixel_mask !== want.mask ||
                rsp_paint_colour !== want.colour || rsp_cursor_x_now !== want.cx ||
                rsp_cursor_y_now !== want.cy || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t want k=%0d xy=%0d,%0d m=%h c=%h cur=%0d,%0d last=%b",
                           $realtime, want.kind, want.px, want.py, want.mask,
                           want.colour, want.cx, want.cy, want.last);
                  $display("%0t got  k=%0d xy=%0d,%0d m=%h c=%h cur=%0d,%0d last=%b",
                           $realtime, rsp_kind, rsp_pixel_x, rsp_pixel_y,
                           rsp_pixel_mask, rsp_paint_colour, rsp_cursor_x_now,
                           rsp_cursor_y_now, rsp_last);
               end
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("text_console_glyph_renderer_top test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main
   initial begin
      foreach (faces[i]) begin
         faces[i] = 8'($urandom);
         if (faces[i] == NEWLINE_CODE) faces[i] = 8'h0B;
      end

      plan_known(cmd_of(OP_LOAD, 8'h00, 0, 8'h80, 0, 0, 32'h0), RSP_ACK, 32'h0, 0, 0);
      plan_known(cmd_of(OP_CHAR, NEWLINE_CODE, 0, 0, 0, 0, 32'h0), RSP_ACK, 32'h0, 0, 17);
      plan_known(cmd_of(OP_CURSOR, 0, 0, 0, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF),
                 RSP_ACK, 32'h0, COORD_MAX, COORD_MAX);
      plan_known(cmd_of(OP_CLEAR, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), RSP_CLEAR,
                 32'hFFFF_FFFF, 0, 0);
      plan_known(cmd_of(OP_CLEAR, 0, 0, 0, 0, 0, 32'h0), RSP_CLEAR, 32'h0, 0, 0);
      plan_reg(CSR_GLYPH_HEIGHT, 2);
      plan(cmd_of(OP_LOAD, 8'hFF, 0, 8'hFF, 0, 0, 32'h0));
      plan(cmd_of(OP_LOAD, 8'hFF, 1, 8'h00, 0, 0, 32'h0));
      plan(cmd_of(OP_LOAD, 8'h00, 1, 8'h7F, 0, 0, 32'h0));
      plan(cmd_of(OP_LOAD, 8'h20, 31, 8'hAA, 0, 0, 32'h0));  // row past the store
      plan(cmd_of(OP_CHAR, 8'hFF, 0, 0, 0, 0, 32'h0));
      plan(cmd_of(OP_CHAR, 8'h00, 0, 0, 0, 0, 32'h0));
      plan(cmd_of(OP_CURSOR, 0, 0, 0, 4087, 0, 32'h1234_5678));
      plan(cmd_of(OP_CHAR, 8'hFF, 0, 0, 0, 0, 32'h0));       // wraps first
      plan(cmd_of(OP_CURSOR, 0, 0, 0, 0, COORD_MAX, 32'h00FF_00FF));
      plan(cmd_of(OP_CHAR, 8'h00, 0, 0, 0, 0, 32'h0));       // second row wraps to y 0
      plan_known(cmd_of(OP_CHAR, NEWLINE_CODE, 0, 0, 0, 0, 32'h0), RSP_CLEAR, 32'h0, 0, 0);
      plan_reg(CSR_SCREEN_WIDTH, COORD_MAX);
      plan(cmd_of(OP_CURSOR, 0, 0, 0, 4087, 10, 32'hA5A5_A5A5));
      plan(cmd_of(OP_CHAR, 8'hFF, 0, 0, 0, 0, 32'h0));       // column saturates
      plan(cmd_of(OP_CHAR, 8'h00, 0, 0, 0, 0, 32'h0));
      plan_reg(CSR_GLYPH_HEIGHT, 0);                          // acts as one row
      plan(cmd_of(OP_CHAR, 8'h00, 0, 0, 0, 0, 32'h0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].reg_write) begin
            wait_drained();
            write_reg(script[i].reg_idx, script[i].reg_val);
         end else begin
            if (script[i].cmd.op == OP_CHAR && script[i].cmd.char_code != NEWLINE_CODE)
               preload_glyph(script[i].cmd.char_code);
            send_cmd(script[i].cmd);
            if (script[i].known)
               pending_paints[pending_paints.size() - 1] = script[i].want;
         end
      end

      run_setting(1024, 768, 16, 6, 46, 1'b1);
      run_setting(COORD_MAX, COORD_MAX, 32, 46, 6, 1'b0);
      run_setting(8, 8, 1, 46, 6, 1'b0);
      run_setting(200, 60, 5, 0, 0, 1'b0);

      wait_drained();
      repeat (40) @(posedge clock);
      if (pending_paints.size() != 0) mismatches++;

      $display("%0d items sent, %0d results checked, %0d register writes, %0d mismatches",
               items_sent, paints_checked, reg_writes, mismatches);
      $display("covered draws, wraps, line clears, ignored loads and four random settings");
      if (mismatches == 0) begin
         $display("text_console_glyph_renderer_top test passed");
      end else begin
         $display("text_console_glyph_renderer_top test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tcgr_pkg.sv
rtl/tcgr_fifo.sv
rtl/tcgr_front.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer_top.sv
rtl/tcgr_checker.sv
tb/text_console_glyph_renderer_top_tb.sv
